// ===== rtl/core/grtr_pkg.sv =====
`default_nettype none
package grtr_pkg;

    localparam int SOURCE_DEPTH = 8192;
    localparam int RAMP_DEPTH   = 4096;
    localparam int STORE_WORDS  = 3 * SOURCE_DEPTH;

    localparam int ADDR_W     = $clog2(STORE_WORDS);
    localparam int CNT_W      = 16;
    localparam int BYTES_W    = 2;
    localparam int SAMPLE_W   = 16;
    localparam int IDX_W      = 12;
    localparam int POINTS_W   = 13;
    localparam int STATUS_W   = 2;
    localparam int TRIPLE_W   = CNT_W + 2;
    localparam int LO_W       = $clog2(SOURCE_DEPTH);
    localparam int DEN_W      = $clog2(RAMP_DEPTH);
    localparam int FRAC_W     = 16;
    localparam int NUM_W      = IDX_W + LO_W;
    localparam int DIV_W      = ((NUM_W + FRAC_W + 1) / 2) * 2;
    localparam int DIV_STEPS  = DIV_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CFG    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd3;

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_ENTRY_BYTES = 1'b1;

    localparam logic [BYTES_W-1:0] BYTES_ONE = 2'd1;
    localparam logic [BYTES_W-1:0] BYTES_TWO = 2'd2;

    typedef struct packed {
        logic                cmd;
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    out_index;
    } t_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic [STATUS_W-1:0] status;
        logic [POINTS_W-1:0] ramp_points;
    } t_result;

    typedef struct packed {
        logic       load;
        logic       query;
        logic       div_step;
        logic       rd_a;
        logic       rd_b;
        logic       mul;
        logic       acc;
        logic       emit;
        logic [1:0] chan;
    } t_cmd;

    typedef struct packed {
        logic query_ok;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/core/grtr_cfg.sv =====
`default_nettype none
module grtr_cfg
    import grtr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [CNT_W-1:0]   o_entry_count,
    output logic      [BYTES_W-1:0] o_entry_bytes,
    output logic                    o_cfg_wr
);

    logic [CNT_W-1:0]   r_count;
    logic [BYTES_W-1:0] r_bytes;
    logic               wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(256);
            r_bytes <= BYTES_TWO;
        end else if (wr) begin
            unique case (paddr[2])
                REG_ENTRY_COUNT: r_count <= pwdata[CNT_W-1:0];
                REG_ENTRY_BYTES: r_bytes <= pwdata[BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ENTRY_COUNT: prdata = {{(PDATA_W-CNT_W){1'b0}}, r_count};
            REG_ENTRY_BYTES: prdata = {{(PDATA_W-BYTES_W){1'b0}}, r_bytes};
            default:         prdata = '0;
        endcase
    end

    assign o_entry_count = r_count;
    assign o_entry_bytes = r_bytes;
    assign o_cfg_wr      = wr;

endmodule
`default_nettype wire

// ===== rtl/core/grtr_ctrl.sv =====
`default_nettype none
module grtr_ctrl
    import grtr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire logic  i_cmd,
    input  wire t_stat i_stat,
    output logic       o_busy,
    output t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RA   = 3'd2;
    localparam logic [2:0] S_RB   = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]           r_chan, n_chan;
    logic                 accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start & ~o_busy;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_chan  = r_chan;
        o_cmd   = '0;
        o_cmd.chan = r_chan;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load  = accept & (i_cmd == CMD_LOAD);
                o_cmd.query = accept & (i_cmd == CMD_QUERY);
                if (o_cmd.query && i_stat.query_ok) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_RA;
                    n_chan  = '0;
                end
            end
            S_RA: begin
                o_cmd.rd_a = 1'b1;
                n_state = S_RB;
            end
            S_RB: begin
                o_cmd.rd_b = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_chan == 2'd2) begin
                    n_state = S_EMIT;
                end else begin
                    n_chan  = r_chan + 1'b1;
                    n_state = S_RA;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_chan  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_chan  <= n_chan;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/grtr_dp.sv =====
`default_nettype none
module grtr_dp
    import grtr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire t_item              i_item,
    input  wire logic [CNT_W-1:0]   i_entry_count,
    input  wire logic [BYTES_W-1:0] i_entry_bytes,
    input  wire logic               i_cfg_wr,
    output t_stat                   o_stat,
    output logic                    o_result_valid,
    output t_result                 o_result
);

    logic [SAMPLE_W-1:0] mem [0:STORE_WORDS-1];

    logic [ADDR_W-1:0]   r_ptr;
    logic [SAMPLE_W-1:0] r_rd;
    logic [DIV_W-1:0]    r_dq;
    logic [DEN_W-1:0]    r_rem;
    logic [DEN_W-1:0]    r_den;
    logic [POINTS_W-1:0] r_points;
    logic [ADDR_W-1:0]   r_base;
    logic [SAMPLE_W-1:0] r_a;
    logic signed [33:0]  r_prod;
    logic [SAMPLE_W-1:0] r_red, r_green, r_blue;
    logic                r_valid;
    t_result             r_out;

    logic                cfg_ok;
    logic [TRIPLE_W-1:0] triple;
    logic [TRIPLE_W-1:0] limit;
    logic                load_en;
    logic [POINTS_W-1:0] points;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    cnt_m1;
    logic [NUM_W-1:0]    num;
    logic [POINTS_W-1:0] pts_m1;
    logic [DEN_W:0]      t1, t2, rem1;
    logic                ge1, ge2;
    logic [LO_W-1:0]     lo, hi;
    logic [LO_W:0]       lo_p1;
    logic [FRAC_W-1:0]   frac;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] scaled;
    logic signed [16:0]  diff;
    logic signed [33:0]  rnd;
    logic signed [17:0]  res;

    assign cfg_ok = (i_entry_count >= CNT_W'(2)) &&
                    (i_entry_count <= CNT_W'(SOURCE_DEPTH)) &&
                    ((i_entry_bytes == BYTES_ONE) || (i_entry_bytes == BYTES_TWO));
    assign triple  = {2'b00, i_entry_count} + {1'b0, i_entry_count, 1'b0};
    assign limit   = cfg_ok ? triple : TRIPLE_W'(STORE_WORDS);
    assign load_en = i_cmd.load && ({{(TRIPLE_W-ADDR_W){1'b0}}, r_ptr} < limit) &&
                     (r_ptr < ADDR_W'(STORE_WORDS));

    assign points = (i_entry_count < CNT_W'(RAMP_DEPTH)) ?
                    i_entry_count[POINTS_W-1:0] : POINTS_W'(RAMP_DEPTH);

    always_comb begin
        if (!cfg_ok) begin
            status = ST_BAD_CFG;
        end else if ({1'b0, i_item.out_index} >= points) begin
            status = ST_RANGE;
        end else if ({{(TRIPLE_W-ADDR_W){1'b0}}, r_ptr} < triple) begin
            status = ST_INCOMPLETE;
        end else begin
            status = ST_OK;
        end
    end
    assign o_stat.query_ok = (status == ST_OK);

    assign cnt_m1 = i_entry_count - 1'b1;
    assign num    = i_item.out_index * cnt_m1[LO_W-1:0];
    assign pts_m1 = points - 1'b1;

    // two restoring division steps per cycle
    assign t1   = {r_rem, r_dq[DIV_W-1]};
    assign ge1  = t1 >= {1'b0, r_den};
    assign rem1 = ge1 ? (t1 - {1'b0, r_den}) : t1;
    assign t2   = {rem1[DEN_W-1:0], r_dq[DIV_W-2]};
    assign ge2  = t2 >= {1'b0, r_den};

    assign lo    = r_dq[FRAC_W +: LO_W];
    assign frac  = r_dq[FRAC_W-1:0];
    assign lo_p1 = {1'b0, lo} + 1'b1;
    assign hi    = ({{(CNT_W-LO_W-1){1'b0}}, lo_p1} < i_entry_count) ?
                   lo_p1[LO_W-1:0] : lo;

    assign rd_addr = r_base + (i_cmd.rd_b ? ADDR_W'(hi) : ADDR_W'(lo));
    assign scaled  = (i_entry_bytes == BYTES_ONE) ? {r_rd[7:0], r_rd[7:0]} : r_rd;
    assign diff    = $signed({1'b0, scaled}) - $signed({1'b0, r_a});
    assign rnd     = r_prod + 34'sd32768;
    assign res     = $signed({2'b00, r_a}) + rnd[33:16];

    always_ff @(posedge i_clk) begin
        if (load_en) begin
            mem[r_ptr] <= i_item.sample;
        end
        if (i_cmd.rd_a || i_cmd.rd_b) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cfg_wr) begin
            r_ptr <= '0;
        end else if (load_en) begin
            r_ptr <= r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_dq     <= DIV_W'({num, {FRAC_W{1'b0}}});
            r_rem    <= '0;
            r_den    <= pts_m1[DEN_W-1:0];
            r_points <= points;
            r_base   <= '0;
        end
        if (i_cmd.div_step) begin
            r_dq  <= {r_dq[DIV_W-3:0], ge1, ge2};
            r_rem <= ge2 ? (t2[DEN_W-1:0] - r_den) : t2[DEN_W-1:0];
        end
        if (i_cmd.rd_b) begin
            r_a <= scaled;
        end
        if (i_cmd.mul) begin
            r_prod <= diff * $signed({1'b0, frac});
        end
        if (i_cmd.acc) begin
            r_base <= r_base + i_entry_count[ADDR_W-1:0];
            case (i_cmd.chan)
                2'd0:    r_red   <= res[SAMPLE_W-1:0];
                2'd1:    r_green <= res[SAMPLE_W-1:0];
                default: r_blue  <= res[SAMPLE_W-1:0];
            endcase
        end
        if (i_cmd.query && (status != ST_OK)) begin
            r_out.red         <= '0;
            r_out.green       <= '0;
            r_out.blue        <= '0;
            r_out.status      <= status;
            r_out.ramp_points <= cfg_ok ? points : '0;
        end else if (i_cmd.emit) begin
            r_out.red         <= r_red;
            r_out.green       <= r_green;
            r_out.blue        <= r_blue;
            r_out.status      <= ST_OK;
            r_out.ramp_points <= r_points;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.query && (status != ST_OK)) || i_cmd.emit;
        end
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_out;

endmodule
`default_nettype wire

// ===== rtl/core/gamma_ramp_table_resampler_top.sv =====
// Gamma ramp table resampler.
// Input channel: an item is taken at a clock edge where start is high and
// busy is low. cmd = load writes one sample into the table (red entries,
// then green, then blue); cmd = query asks for one resampled ramp entry.
// Result channel: o_result is shown for one cycle with o_result_valid high;
// one result per query, none per load. The receiver cannot stall.
// Loads never raise busy.
// A query that fails a check (bad configuration, index out of range,
// table incomplete) gives its result in the next cycle, busy stays low.
// A good query holds busy while the two-bit-per-cycle divider runs, then
// for each channel in turn reads two table entries, multiplies and
// accumulates on the single table read port and shared multiplier, then
// loads the output register; the result is shown once busy has fallen.
// Configuration: APB, entry_count at 0x0, entry_bytes at 0x4; a write
// restarts the table load. Write only while no query is in flight.
// Reset (i_rst_n low, synchronous) gives entry_count 256, entry_bytes 2 and
// an empty table; table contents are undefined until loaded.
`default_nettype none
module gamma_ramp_table_resampler_top
    import grtr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_item              i_item,
    output logic                    o_result_valid,
    output t_result                 o_result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic [CNT_W-1:0]   entry_count;
    logic [BYTES_W-1:0] entry_bytes;
    logic               cfg_wr;
    t_cmd               cmd;
    t_stat              stat;

    grtr_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_entry_count (entry_count),
        .o_entry_bytes (entry_bytes),
        .o_cfg_wr      (cfg_wr)
    );

    grtr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_item.cmd),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    grtr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item         (i_item),
        .i_entry_count  (entry_count),
        .i_entry_bytes  (entry_bytes),
        .i_cfg_wr       (cfg_wr),
        .o_stat         (stat),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
`default_nettype wire

// ===== rtl/core/grtr_chk.sv =====
`default_nettype none
module grtr_chk
    import grtr_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire t_item   i_item,
    input wire logic    o_result_valid,
    input wire t_result o_result
);

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status != ST_OK)) |->
        (o_result.red == '0) && (o_result.green == '0) && (o_result.blue == '0))
        else $error("error transaction carries nonzero color");

    a_bad_cfg_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status == ST_BAD_CFG)) |->
        (o_result.ramp_points == '0))
        else $error("bad configuration transaction reports ramp points");

    a_points_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status != ST_BAD_CFG)) |->
        (o_result.ramp_points >= POINTS_W'(2)) &&
        (o_result.ramp_points <= POINTS_W'(RAMP_DEPTH)))
        else $error("ramp points out of range");

    a_query_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.cmd == CMD_QUERY)) |=> (busy || o_result_valid))
        else $error("query transaction neither started nor answered");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.cmd == CMD_LOAD)) |=> (!busy && !o_result_valid))
        else $error("load transaction raised busy or a result");

endmodule

bind gamma_ramp_table_resampler_top grtr_chk u_grtr_chk (.*);
`default_nettype wire
